@@ hw/rtl/acesf_pkg.sv @@
// ============================================================================
// ACES filmic tone mapper package
// Shared types, fixed-point constants and the gamma threshold function.
// ============================================================================
package acesf_pkg;

    // Field widths of the words on the channels
    localparam int IN_W   = 24;
    localparam int GAIN_W = 16;
    localparam int DISP_W = 8;

    localparam logic [GAIN_W-1:0] EXPOSURE_RESET = 16'd256;

    // Scaled working value: unsigned Q.16, saturated at 4096.0
    localparam int V_W = 29;
    localparam logic [V_W-1:0] V_SAT     = 29'h1000_0000;
    localparam logic [29:0]    SAT_LIMIT = 30'd805306368;   // three times the saturation value
    localparam logic [31:0]    RECIP_3   = 32'hAAAA_AAAB;    // ceil(2^33 / 3)

    // Rational fit constants
    localparam int X_W = 29;
    localparam logic [29:0] FIT_A = 30'd1611;
    localparam logic [59:0] FIT_B = 60'd388853;
    localparam logic [16:0] FIT_C = 17'd64470;
    localparam logic [30:0] FIT_D = 31'd28374;
    localparam logic [59:0] FIT_E = 60'd1022550109;

    // Divider geometry
    localparam int MAG_W = 59;
    localparam int D_W   = 42;
    localparam int Q_W   = 17;
    localparam int F_W   = 18;

    // Colour matrices, Q.16
    localparam logic [15:0] MAT_IN [3][3] = '{
        '{16'd39137, 16'd23238, 16'd3161},
        '{16'd4981,  16'd59529, 16'd1026},
        '{16'd1861,  16'd8771,  16'd54904}
    };
    localparam logic signed [17:0] MAT_OUT [3][3] = '{
        '{18'sd105169, -18'sd34805, -18'sd4828},
        '{-18'sd6690,  18'sd72622,  -18'sd396},
        '{-18'sd214,   -18'sd4768,  18'sd70518}
    };

    // Pipeline depths of the sub-blocks
    localparam int SCALE_LAT = 4;
    localparam int LANE_LAT  = 6 + Q_W;
    localparam int MERGE_LAT = 11;
    localparam int TOTAL_LAT = SCALE_LAT + LANE_LAT + MERGE_LAT;

    // Channel words
    typedef struct packed {
        logic [IN_W-1:0] lin_red;
        logic [IN_W-1:0] lin_green;
        logic [IN_W-1:0] lin_blue;
    } t_pix_word;

    typedef struct packed {
        logic [DISP_W-1:0] disp_red;
        logic [DISP_W-1:0] disp_green;
        logic [DISP_W-1:0] disp_blue;
    } t_disp_word;

    typedef struct packed {
        logic [GAIN_W-1:0] exposure_gain;
    } t_cfg_word;

    // Smallest quantised level whose gamma code reaches v, worked out exactly
    // at elaboration: least L with L^5 * 255^11 >= v^11 * top^5.
    function automatic int unsigned gamma_thr(input int g, input int v);
        logic [199:0] rhs;
        logic [199:0] lhs;
        logic [199:0] pv;
        logic [199:0] ptop;
        logic [199:0] p255;
        logic [199:0] pm;
        int unsigned  top;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int           i;
        int           j;
        top  = (32'd1 << g) - 32'd1;
        pv   = 200'd1;
        p255 = 200'd1;
        ptop = 200'd1;
        for (i = 0; i < 11; i++) begin
            pv   = pv * 200'(v);
            p255 = p255 * 200'd255;
        end
        for (i = 0; i < 5; i++) begin
            ptop = ptop * 200'(top);
        end
        rhs = pv * ptop;
        lo  = 0;
        hi  = top;
        for (i = 0; i < 16; i++) begin
            if (lo < hi) begin
                mid = (lo + hi) >> 1;
                pm  = 200'd1;
                for (j = 0; j < 5; j++) begin
                    pm = pm * 200'(mid);
                end
                lhs = pm * p255;
                if (lhs >= rhs) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
        end
        return lo;
    endfunction

endpackage

@@ hw/rtl/acesf_if.sv @@
// ============================================================================
// ACES filmic tone mapper channels
// Valid/ready channels for pixel input, display output and configuration.
// ============================================================================
interface acesf_pix_if;
    import acesf_pkg::*;
    logic      valid;
    logic      ready;
    t_pix_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface acesf_disp_if;
    import acesf_pkg::*;
    logic       valid;
    logic       ready;
    t_disp_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface acesf_cfg_if;
    import acesf_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/aces_filmic_tone_mapper_unit.sv @@
// ============================================================================
// ACES filmic tone mapper
// Linear HDR RGB pixel in, gamma encoded 8-bit RGB pixel out.
// ============================================================================
// The unit takes one pixel word per clock unless the output is held, and
// the depth of its pipeline is set mostly by the 17-stage divider of the
// rational fit in each colour lane. All stages advance together, so while a
// finished word is held at the output the whole pipeline, and the input,
// waits. The exposure register is written through its own channel, which is
// always ready, and should be changed only while no pixel is in flight.
module aces_filmic_tone_mapper_unit #(
    parameter int INPUT_FRAC_BITS  = 16,
    parameter int GAMMA_TABLE_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acesf_pix_if.sink   i_pix,
    acesf_cfg_if.sink   i_cfg,
    acesf_disp_if.source o_disp
);
    import acesf_pkg::*;

    logic [GAIN_W-1:0]     r_gain;
    logic [TOTAL_LAT-1:0]  r_vld;
    logic                  w_en;
    logic [V_W-1:0]        w_v [3];
    logic signed [F_W-1:0] w_f [3];
    logic [DISP_W-1:0]     w_code [3];
    logic [IN_W-1:0]       w_lin [3];

    // Pipeline moves unless a finished word is held at the output
    assign w_en        = !r_vld[TOTAL_LAT-1] || o_disp.ready;
    assign i_pix.ready = w_en;
    assign i_cfg.ready = 1'b1;

    // Exposure register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= EXPOSURE_RESET;
        end else if (i_cfg.valid) begin
            r_gain <= i_cfg.payload.exposure_gain;
        end
    end

    // Valid flags following the words through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[TOTAL_LAT-2:0], i_pix.valid};
        end
    end

    assign w_lin[0] = i_pix.payload.lin_red;
    assign w_lin[1] = i_pix.payload.lin_green;
    assign w_lin[2] = i_pix.payload.lin_blue;

    // Per-channel scaling and colour lanes
    for (genvar gc = 0; gc < 3; gc++) begin : g_lane
        acesf_scale #(
            .INPUT_FRAC_BITS (INPUT_FRAC_BITS)
        ) u_scale (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_lin  (w_lin[gc]),
            .i_gain (r_gain),
            .o_v    (w_v[gc])
        );

        acesf_lane #(
            .ROW (gc)
        ) u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_v   (w_v),
            .o_f   (w_f[gc])
        );
    end

    acesf_merge #(
        .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_f    (w_f),
        .o_code (w_code)
    );

    assign o_disp.valid              = r_vld[TOTAL_LAT-1];
    assign o_disp.payload.disp_red   = w_code[0];
    assign o_disp.payload.disp_green = w_code[1];
    assign o_disp.payload.disp_blue  = w_code[2];

`ifndef SYNTHESIS
    // A held output word must stop the input side
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_disp.valid && !o_disp.ready) |-> !i_pix.ready)
        else $error("input accepted while output word is held");

    // While stalled the valid flags must not move
    a_stall_holds_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid flags moved during a stall");

    // Reset restores unity exposure
    a_reset_gain: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_gain == EXPOSURE_RESET))
        else $error("exposure not at its reset value after reset");

    // A word accepted while moving enters the first valid flag
    a_accept_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_vld[0])
        else $error("accepted word not tracked");
`endif

endmodule

@@ hw/rtl/acesf_scale.sv @@
// ============================================================================
// Exposure scaling
// Multiplies one channel by the exposure gain and divides by 0.6, saturating.
// ============================================================================
module acesf_scale #(
    parameter int INPUT_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [acesf_pkg::IN_W-1:0]   i_lin,
    input  logic [acesf_pkg::GAIN_W-1:0] i_gain,
    output logic [acesf_pkg::V_W-1:0]    o_v
);
    import acesf_pkg::*;

    localparam int SH = INPUT_FRAC_BITS - 8;

    logic [39:0]    r_prod;
    logic [42:0]    w_t5;
    logic [42:0]    w_t;
    logic [29:0]    r_t;
    logic           r_sat;
    logic           r_sat2;
    logic [61:0]    r_q;
    logic [V_W-1:0] r_v;

    // Times five, then the power-of-two part of the divisor
    assign w_t5 = {3'b000, r_prod} + {1'b0, r_prod, 2'b00};
    assign w_t  = w_t5 >> SH;

    // Divide by three through the reciprocal; exact below 2^32
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_lin * i_gain;
            r_sat  <= (w_t >= 43'(SAT_LIMIT));
            r_t    <= w_t[29:0];
            r_q    <= r_t * RECIP_3;
            r_sat2 <= r_sat;
            r_v    <= r_sat2 ? V_SAT : r_q[61:33];
        end
    end

    assign o_v = r_v;

endmodule

@@ hw/rtl/acesf_div.sv @@
// ============================================================================
// Fit divider
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module acesf_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [acesf_pkg::MAG_W-1:0] i_mag,
    input  logic [acesf_pkg::D_W-1:0]   i_d,
    input  logic                      i_neg,
    output logic [acesf_pkg::Q_W-1:0]   o_q,
    output logic                      o_neg
);
    import acesf_pkg::*;

    logic [MAG_W-1:0] r_rem [Q_W];
    logic [D_W-1:0]   r_d   [Q_W];
    logic [Q_W-1:0]   r_q   [Q_W];
    logic             r_neg [Q_W];

    for (genvar gi = 0; gi < Q_W; gi++) begin : g_stage
        localparam int B = Q_W - 1 - gi;
        logic [MAG_W-1:0] w_rem;
        logic [D_W-1:0]   w_d;
        logic [Q_W-1:0]   w_q;
        logic             w_neg;
        logic [MAG_W:0]   w_dsh;
        logic [MAG_W:0]   w_diff;

        if (gi == 0) begin : g_first
            assign w_rem = i_mag;
            assign w_d   = i_d;
            assign w_q   = '0;
            assign w_neg = i_neg;
        end else begin : g_next
            assign w_rem = r_rem[gi-1];
            assign w_d   = r_d[gi-1];
            assign w_q   = r_q[gi-1];
            assign w_neg = r_neg[gi-1];
        end

        // Trial subtraction of the shifted divisor
        assign w_dsh  = (MAG_W+1)'(w_d) << B;
        assign w_diff = {1'b0, w_rem} - w_dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[gi]   <= w_d;
                r_neg[gi] <= w_neg;
                if (!w_diff[MAG_W]) begin
                    r_rem[gi] <= w_diff[MAG_W-1:0];
                    r_q[gi]   <= w_q | (Q_W'(1) << B);
                end else begin
                    r_rem[gi] <= w_rem;
                    r_q[gi]   <= w_q;
                end
            end
        end
    end

    assign o_q   = r_q[Q_W-1];
    assign o_neg = r_neg[Q_W-1];

endmodule

@@ hw/rtl/acesf_lane.sv @@
// ============================================================================
// Colour lane
// One row of the input matrix followed by the rational fit for one channel.
// ============================================================================
module acesf_lane #(
    parameter int ROW = 0
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [acesf_pkg::V_W-1:0]        i_v [3],
    output logic signed [acesf_pkg::F_W-1:0] o_f
);
    import acesf_pkg::*;

    logic [44:0]        r_p [3];
    logic [46:0]        w_sum;
    logic [X_W-1:0]     r_x;
    logic [29:0]        w_xa;
    logic [58:0]        r_xx;
    logic [45:0]        r_cx;
    logic [X_W-1:0]     r_x3;
    logic [30:0]        w_ya;
    logic [59:0]        r_den_p;
    logic signed [59:0] r_num;
    logic [59:0]        w_den;
    logic [D_W-1:0]     r_d;
    logic [MAG_W-1:0]   r_mag;
    logic               r_neg;
    logic [Q_W-1:0]     w_q;
    logic               w_qneg;
    logic signed [F_W-1:0] r_f;

    // Input matrix row
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_p[k] <= MAT_IN[ROW][k] * i_v[k];
            end
        end
    end

    assign w_sum = 47'(r_p[0]) + 47'(r_p[1]) + 47'(r_p[2]);
    assign w_xa  = 30'(r_x) + FIT_A;
    assign w_ya  = 31'(r_cx[45:16]) + FIT_D;
    assign w_den = r_den_p + FIT_E;

    // Numerator and denominator of the fit
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x     <= w_sum[44:16];
            r_xx    <= r_x * w_xa;
            r_cx    <= r_x * FIT_C;
            r_x3    <= r_x;
            r_num   <= $signed({1'b0, r_xx}) - $signed(FIT_B);
            r_den_p <= r_x3 * w_ya;
            r_d     <= w_den[57:16];
            r_neg   <= r_num[59];
            r_mag   <= r_num[59] ? MAG_W'(-r_num) : r_num[MAG_W-1:0];
        end
    end

    acesf_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_mag (r_mag),
        .i_d   (r_d),
        .i_neg (r_neg),
        .o_q   (w_q),
        .o_neg (w_qneg)
    );

    // Sign restored, so the quotient truncates toward zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f <= w_qneg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
        end
    end

    assign o_f = r_f;

endmodule

@@ hw/rtl/acesf_merge.sv @@
// ============================================================================
// Output merge
// Output matrix across the lanes, clamp and quantise, then gamma encoding.
// ============================================================================
module acesf_merge #(
    parameter int GAMMA_TABLE_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic signed [acesf_pkg::F_W-1:0]  i_f [3],
    output logic [acesf_pkg::DISP_W-1:0]      o_code [3]
);
    import acesf_pkg::*;

    localparam int G = GAMMA_TABLE_BITS;
    localparam logic [G-1:0] TOP = {G{1'b1}};

    logic [G-1:0]       w_thr [256];
    logic signed [35:0] r_mp  [3][3];
    logic signed [37:0] r_s   [3];
    logic [G-1:0]       r_lvl [3];
    logic [G-1:0]       r_glvl [3][8];
    logic [7:0]         r_glo  [3][8];

    // Gamma thresholds, one per output code
    for (genvar gv = 0; gv < 256; gv++) begin : g_thr
        localparam int unsigned TH = gamma_thr(G, gv);
        assign w_thr[gv] = TH[G-1:0];
    end

    for (genvar gc = 0; gc < 3; gc++) begin : g_ch
        logic [31:0]  w_s32;
        logic [32+G:0] w_round;

        assign w_s32   = r_s[gc][31:0];
        assign w_round = {1'b0, w_s32, {G{1'b0}}} - (33+G)'(w_s32)
                         + (33+G)'(33'h0_8000_0000);

        // Output matrix row, clamp and round to the table precision
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int k = 0; k < 3; k++) begin
                    r_mp[gc][k] <= MAT_OUT[gc][k] * i_f[k];
                end
                r_s[gc] <= 38'(r_mp[gc][0]) + 38'(r_mp[gc][1]) + 38'(r_mp[gc][2]);
                if (r_s[gc] <= 38'sd0) begin
                    r_lvl[gc] <= '0;
                end else if (r_s[gc] >= 38'sh1_0000_0000) begin
                    r_lvl[gc] <= TOP;
                end else begin
                    r_lvl[gc] <= w_round[31+G:32];
                end
            end
        end

        // Bitwise search for the largest code whose threshold is reached
        for (genvar gs = 0; gs < 8; gs++) begin : g_gam
            logic [G-1:0] w_lvl;
            logic [7:0]   w_lo;
            logic [7:0]   w_cand;
            if (gs == 0) begin : g_first
                assign w_lvl = r_lvl[gc];
                assign w_lo  = '0;
            end else begin : g_next
                assign w_lvl = r_glvl[gc][gs-1];
                assign w_lo  = r_glo[gc][gs-1];
            end
            assign w_cand = w_lo | (8'd1 << (7 - gs));

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_glvl[gc][gs] <= w_lvl;
                    r_glo[gc][gs]  <= (w_thr[w_cand] <= w_lvl) ? w_cand : w_lo;
                end
            end
        end

        assign o_code[gc] = r_glo[gc][7];
    end

endmodule
